### rtl/jmsl_pkg.sv
// Shared types, constants and the marker classifier for the JPEG marker segment locator.
// Depends on nothing; every other file except jmsl_tb_pkg imports it.
package jmsl_pkg;

    // Widths of file offsets and of the per-kind marker counters
    localparam int OFFSET_BITS = 32;
    localparam int COUNT_BITS  = 8;
    localparam int KIND_BITS   = 4;
    localparam int NUM_KINDS   = 1 << KIND_BITS;
    localparam int LEN_BITS    = 16;

    // Byte codes
    localparam logic [7:0] BYTE_FF    = 8'hFF;
    localparam logic [7:0] BYTE_STUFF = 8'h00;

    // Scan header skip register
    localparam logic [7:0] SKIP_RESET = 8'd14;
    localparam logic [7:0] SKIP_MIN   = 8'd2;

    // Register indexes on the configuration port
    localparam logic REG_SCAN_SKIP = 1'b0;

    // Marker kinds
    localparam logic [KIND_BITS-1:0] KIND_SOF     = 4'd0;
    localparam logic [KIND_BITS-1:0] KIND_DHT     = 4'd1;
    localparam logic [KIND_BITS-1:0] KIND_JPG     = 4'd2;
    localparam logic [KIND_BITS-1:0] KIND_DAC     = 4'd3;
    localparam logic [KIND_BITS-1:0] KIND_RST     = 4'd4;
    localparam logic [KIND_BITS-1:0] KIND_SOI     = 4'd5;
    localparam logic [KIND_BITS-1:0] KIND_EOI     = 4'd6;
    localparam logic [KIND_BITS-1:0] KIND_SOS     = 4'd7;
    localparam logic [KIND_BITS-1:0] KIND_APP     = 4'd13;
    localparam logic [KIND_BITS-1:0] KIND_COM     = 4'd14;
    localparam logic [KIND_BITS-1:0] KIND_UNKNOWN = 4'd15;

    // Parse phase, one-hot
    typedef enum logic [4:0] {
        PH_IDLE      = 5'b00001,
        PH_LEN_HI    = 5'b00010,
        PH_LEN_LO    = 5'b00100,
        PH_PAYLOAD   = 5'b01000,
        PH_SCAN_SKIP = 5'b10000
    } t_phase;

    // One input byte with its framing flags
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_file;
        logic       last_of_file;
    } t_item;

    // One located segment or region
    typedef struct packed {
        logic [KIND_BITS-1:0]   segment_kind;
        logic [COUNT_BITS-1:0]  ordinal;
        logic [OFFSET_BITS-1:0] start_offset;
        logic [OFFSET_BITS-1:0] end_offset;
        logic                   bad_length;
    } t_seg_result;

    // Map a marker code to its kind
    function automatic logic [KIND_BITS-1:0] jmsl_classify(input logic [7:0] code);
        logic [KIND_BITS-1:0] kind;
        begin
            case (code) inside
                8'hC4:         kind = KIND_DHT;
                8'hC8:         kind = KIND_JPG;
                8'hCC:         kind = KIND_DAC;
                [8'hC0:8'hCF]: kind = KIND_SOF;
                [8'hD0:8'hD7]: kind = KIND_RST;
                [8'hD8:8'hDF]: kind = KIND_BITS'(code - 8'hD8 + 8'd5);
                [8'hE0:8'hEF]: kind = KIND_APP;
                [8'hF0:8'hFD]: kind = KIND_JPG;
                8'hFE:         kind = KIND_COM;
                default:       kind = KIND_UNKNOWN;
            endcase
            jmsl_classify = kind;
        end
    endfunction

endpackage

### rtl/jmsl_cfg.sv
// APB-style register block holding the scan header skip.
// Depends on jmsl_pkg for the register index and reset value.
module jmsl_cfg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready,
    output logic [7:0]  o_scan_skip
);
    import jmsl_pkg::*;

    logic [7:0] r_scan_skip;
    logic       wr_en;

    assign o_pready = 1'b1;
    assign wr_en    = i_psel && i_penable && i_pwrite && o_pready;

    // Write the skip register on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_skip <= SKIP_RESET;
        end else if (wr_en && (i_paddr[2] == REG_SCAN_SKIP)) begin
            r_scan_skip <= i_pwdata[7:0];
        end
    end

    // Read back
    assign o_prdata    = (i_paddr[2] == REG_SCAN_SKIP) ? {24'd0, r_scan_skip} : 32'd0;
    assign o_scan_skip = r_scan_skip;

endmodule

### rtl/jmsl_core.sv
// Parse state and the per-byte update of the marker locator: one byte per step.
// Depends on jmsl_pkg for types, kinds and the classifier.
module jmsl_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  jmsl_pkg::t_item       i_item,
    input  logic [7:0]            i_scan_skip,
    output logic                  o_res_valid,
    output jmsl_pkg::t_seg_result o_res
);
    import jmsl_pkg::*;

    // State registers
    t_phase                 r_phase, n_phase;
    logic                   r_ff, n_ff;
    logic [OFFSET_BITS-1:0] r_offset, n_offset;
    logic [7:0]             r_len_hi, n_len_hi;
    logic [LEN_BITS-1:0]    r_remain, n_remain;
    logic [7:0]             r_skip_left, n_skip_left;
    logic                   r_open, n_open;
    logic [OFFSET_BITS-1:0] r_rstart, n_rstart;
    logic [KIND_BITS-1:0]   r_rkind, n_rkind;
    logic [COUNT_BITS-1:0]  r_rord, n_rord;
    logic [COUNT_BITS-1:0]  r_counts [NUM_KINDS];
    logic [COUNT_BITS-1:0]  n_counts [NUM_KINDS];

    // Per-byte terms
    t_phase                 c_phase;
    logic                   c_ff, c_open, first, last;
    logic [7:0]             d;
    logic [OFFSET_BITS-1:0] c_off, mark_pos;
    logic                   is_marker;
    logic [KIND_BITS-1:0]   mkind;
    logic [COUNT_BITS-1:0]  mord;
    logic [LEN_BITS-1:0]    len_word, plen;
    logic                   len_bad;
    logic [7:0]             skip_eff, skip_init;

    assign d     = i_item.data_byte;
    assign first = i_item.first_of_file;
    assign last  = i_item.last_of_file;

    // A first byte sees cleared state
    assign c_phase = first ? PH_IDLE : r_phase;
    assign c_ff    = first ? 1'b0 : r_ff;
    assign c_open  = first ? 1'b0 : r_open;
    assign c_off   = first ? '0 : r_offset;

    assign mark_pos  = c_off - OFFSET_BITS'(1);
    assign is_marker = c_ff && (d != BYTE_STUFF) && (d != BYTE_FF);
    assign mkind     = jmsl_classify(d);
    assign mord      = first ? '0 : r_counts[mkind];

    assign len_word  = {r_len_hi, d};
    assign len_bad   = (len_word < LEN_BITS'(2));
    assign plen      = len_bad ? '0 : len_word - LEN_BITS'(2);

    assign skip_eff  = (i_scan_skip < SKIP_MIN) ? SKIP_MIN : i_scan_skip;
    assign skip_init = skip_eff - SKIP_MIN;

    // Next state and result for the byte at hand
    always_comb begin
        n_phase     = c_phase;
        n_ff        = c_ff;
        n_offset    = c_off + OFFSET_BITS'(1);
        n_len_hi    = r_len_hi;
        n_remain    = r_remain;
        n_skip_left = r_skip_left;
        n_open      = c_open;
        n_rstart    = r_rstart;
        n_rkind     = r_rkind;
        n_rord      = r_rord;
        for (int i = 0; i < NUM_KINDS; i++) begin
            n_counts[i] = first ? '0 : r_counts[i];
        end
        o_res_valid = 1'b0;
        o_res       = '0;

        case (c_phase)
            PH_LEN_HI: begin
                n_len_hi = d;
                n_phase  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                o_res_valid        = 1'b1;
                o_res.segment_kind = r_rkind;
                o_res.ordinal      = r_rord;
                o_res.start_offset = c_off + OFFSET_BITS'(1);
                o_res.end_offset   = c_off + OFFSET_BITS'(plen);
                o_res.bad_length   = len_bad;
                n_remain           = plen;
                n_phase            = (plen != '0) ? PH_PAYLOAD : PH_IDLE;
            end
            PH_PAYLOAD: begin
                n_remain = (r_remain != '0) ? r_remain - LEN_BITS'(1) : '0;
                if (n_remain == '0) begin
                    n_phase = PH_IDLE;
                end
            end
            PH_SCAN_SKIP: begin
                n_skip_left = (r_skip_left != '0) ? r_skip_left - 8'd1 : 8'd0;
                if (n_skip_left == 8'd0) begin
                    n_phase = PH_IDLE;
                    n_open  = !last;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (is_marker) begin
                    if (mord != {COUNT_BITS{1'b1}}) begin
                        n_counts[mkind] = mord + COUNT_BITS'(1);
                    end
                    n_ff = 1'b0;
                    // Close the open region at the byte before the marker
                    if (c_open) begin
                        o_res_valid        = 1'b1;
                        o_res.segment_kind = r_rkind;
                        o_res.ordinal      = r_rord;
                        o_res.start_offset = r_rstart;
                        o_res.end_offset   = c_off - OFFSET_BITS'(2);
                        n_open             = 1'b0;
                    end
                    if ((mkind == KIND_RST) || (mkind == KIND_SOI) || (mkind == KIND_EOI)) begin
                        if (last) begin
                            if (!c_open) begin
                                o_res_valid        = 1'b1;
                                o_res.segment_kind = mkind;
                                o_res.ordinal      = mord;
                                o_res.start_offset = mark_pos;
                                o_res.end_offset   = c_off;
                            end
                        end else begin
                            n_open   = 1'b1;
                            n_rstart = mark_pos;
                            n_rkind  = mkind;
                            n_rord   = mord;
                        end
                    end else if (mkind == KIND_SOS) begin
                        n_rkind     = mkind;
                        n_rord      = mord;
                        n_rstart    = mark_pos + OFFSET_BITS'(skip_eff);
                        n_skip_left = skip_init;
                        if (skip_init == 8'd0) begin
                            n_open = !last;
                        end else begin
                            n_phase = PH_SCAN_SKIP;
                        end
                    end else begin
                        n_rkind = mkind;
                        n_rord  = mord;
                        n_phase = PH_LEN_HI;
                    end
                end else begin
                    n_ff = (d == BYTE_FF);
                end
            end
        endcase

        // End of file: close what is open and return to idle
        if (last) begin
            if (n_open && !o_res_valid) begin
                o_res_valid        = 1'b1;
                o_res.segment_kind = n_rkind;
                o_res.ordinal      = n_rord;
                o_res.start_offset = n_rstart;
                o_res.end_offset   = c_off;
                o_res.bad_length   = 1'b0;
            end
            n_open      = 1'b0;
            n_phase     = PH_IDLE;
            n_ff        = 1'b0;
            n_remain    = '0;
            n_skip_left = 8'd0;
        end
    end

    // Advance state on each step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_ff        <= 1'b0;
            r_offset    <= '0;
            r_len_hi    <= 8'd0;
            r_remain    <= '0;
            r_skip_left <= 8'd0;
            r_open      <= 1'b0;
            r_rstart    <= '0;
            r_rkind     <= '0;
            r_rord      <= '0;
            for (int i = 0; i < NUM_KINDS; i++) begin
                r_counts[i] <= '0;
            end
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_ff        <= n_ff;
            r_offset    <= n_offset;
            r_len_hi    <= n_len_hi;
            r_remain    <= n_remain;
            r_skip_left <= n_skip_left;
            r_open      <= n_open;
            r_rstart    <= n_rstart;
            r_rkind     <= n_rkind;
            r_rord      <= n_rord;
            for (int i = 0; i < NUM_KINDS; i++) begin
                r_counts[i] <= n_counts[i];
            end
        end
    end

    // A region is only open between markers, never inside a length field or skip
    a_open_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open |-> (r_phase == PH_IDLE))
        else $error("region open outside idle phase");

    // A pending FF is only tracked while seeking markers
    a_ff_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ff |-> (r_phase == PH_IDLE))
        else $error("FF pending outside idle phase");

    // The final byte leaves nothing open
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && last) |=> ((r_phase == PH_IDLE) && !r_open && !r_ff))
        else $error("state left open after last byte");

    // The offset advances by one per byte
    a_offset_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |=> (r_offset == $past(c_off) + OFFSET_BITS'(1)))
        else $error("offset did not advance by one");

endmodule

### rtl/jpeg_marker_segment_locator.sv
// Top level of the JPEG marker segment locator: stream ports, input and result registers.
// Depends on jmsl_pkg, jmsl_cfg and jmsl_core.
//
// Feed the file one byte per request on the slave stream, tuser high on the first byte
// and tlast on the final one. The block takes one byte every clock while input ready is
// high: each byte is held in an input register, the parse update and result selection
// run on the held byte, and any located segment or region lands in the result register
// when that byte steps. Input ready drops only while a byte that produces a result
// waits behind an unread result that the master side is stalling.
// Write scan_header_skip over the APB port only while no bytes are in flight.
module jpeg_marker_segment_locator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input byte stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tuser,   // [0] first_of_file
    input  logic        i_s_axis_tlast,   // last_of_file
    // Located segments
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [79:0] o_m_axis_tdata,   // [3:0] segment_kind, [11:4] ordinal,
                                          // [43:12] start_offset, [75:44] end_offset,
                                          // [79:76] zero
    output logic        o_m_axis_tuser,   // [0] bad_length
    // Configuration
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);
    import jmsl_pkg::*;

    logic        r_in_valid;
    t_item       r_in;
    logic        r_out_valid;
    t_seg_result r_out;

    logic        step, out_free, res_valid;
    t_seg_result res;
    logic [7:0]  scan_skip;

    jmsl_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_psel      (i_psel),
        .i_penable   (i_penable),
        .i_pwrite    (i_pwrite),
        .i_paddr     (i_paddr),
        .i_pwdata    (i_pwdata),
        .o_prdata    (o_prdata),
        .o_pready    (o_pready),
        .o_scan_skip (scan_skip)
    );

    jmsl_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (r_in),
        .i_scan_skip (scan_skip),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Advance the held byte unless its result has nowhere to go
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign step            = r_in_valid && (!res_valid || out_free);
    assign o_s_axis_tready = !r_in_valid || step;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in.data_byte     <= i_s_axis_tdata;
            r_in.first_of_file <= i_s_axis_tuser;
            r_in.last_of_file  <= i_s_axis_tlast;
        end
    end

    // Result register: load on a producing step, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'd0, r_out.end_offset, r_out.start_offset,
                              r_out.ordinal, r_out.segment_kind};
    assign o_m_axis_tuser  = r_out.bad_length;

    // A held result is never overwritten while the master side stalls
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |-> !(step && res_valid))
        else $error("result overwritten while stalled");

    // A byte that is held and not stepped blocks the input
    a_hold_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !step) |-> !o_s_axis_tready)
        else $error("input accepted while a byte is held");

    // A stepped byte with a result shows up on the master side next cycle
    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && res_valid) |=> o_m_axis_tvalid)
        else $error("result lost after step");

endmodule

### tb/jmsl_tb_pkg.sv
`timescale 1ns / 1ps
// Marker code constants shared by the locator checker and the stimulus top.
// Depends on nothing; the checker and the testbench top import it.
package jmsl_tb_pkg;

    // Marker codes that follow an FF byte
    localparam logic [7:0] MK_UNKNOWN_FIRST = 8'h01;
    localparam logic [7:0] MK_UNKNOWN_LAST  = 8'hBF;
    localparam logic [7:0] MK_SOF_FIRST     = 8'hC0;
    localparam logic [7:0] MK_DHT           = 8'hC4;
    localparam logic [7:0] MK_JPG           = 8'hC8;
    localparam logic [7:0] MK_DAC           = 8'hCC;
    localparam logic [7:0] MK_SOF_LAST      = 8'hCF;
    localparam logic [7:0] MK_RST_FIRST     = 8'hD0;
    localparam logic [7:0] MK_RST_LAST      = 8'hD7;
    localparam logic [7:0] MK_SOI           = 8'hD8;
    localparam logic [7:0] MK_EOI           = 8'hD9;
    localparam logic [7:0] MK_SOS           = 8'hDA;
    localparam logic [7:0] MK_DQT           = 8'hDB;
    localparam logic [7:0] MK_EXP           = 8'hDF;
    localparam logic [7:0] MK_APP_FIRST     = 8'hE0;
    localparam logic [7:0] MK_APP_LAST      = 8'hEF;
    localparam logic [7:0] MK_JPG_FIRST     = 8'hF0;
    localparam logic [7:0] MK_JPG_LAST      = 8'hFD;
    localparam logic [7:0] MK_COM           = 8'hFE;

endpackage

### tb/jmsl_segment_checker.sv
`timescale 1ns / 1ps
// Checker for the JPEG marker segment locator: tracks accepted bytes and register writes,
// predicts the located segments and compares them with the result stream.
// Depends on jmsl_pkg and jmsl_tb_pkg.
module jmsl_segment_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] data_byte
    input  logic        i_s_tuser,    // [0] first_of_file
    input  logic        i_s_tlast,    // last_of_file
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [79:0] i_m_tdata,    // [3:0] kind, [11:4] ordinal, [43:12] start, [75:44] end
    input  logic        i_m_tuser,    // [0] bad_length
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending
);
    import jmsl_pkg::*;
    import jmsl_tb_pkg::*;

    localparam int MAX_REPORTS = 10;

    // Shadow of the locator state
    logic [7:0]             skip_reg;
    t_phase                 phase;
    logic                   ff_seen;
    logic [OFFSET_BITS-1:0] byte_offset;
    logic [7:0]             len_hi;
    logic [LEN_BITS-1:0]    pay_left;
    logic [7:0]             skip_left;
    logic                   region_open;
    logic [OFFSET_BITS-1:0] region_start;
    logic [KIND_BITS-1:0]   region_kind;
    logic [COUNT_BITS-1:0]  region_ord;
    logic [COUNT_BITS-1:0]  kind_count [NUM_KINDS];

    t_seg_result expected_segments [$];
    t_seg_result seg_want;
    t_seg_result seg_got;
    int          report_count;

    // Sort a marker code into its kind
    function automatic logic [KIND_BITS-1:0] marker_kind(input logic [7:0] code);
        logic [KIND_BITS-1:0] k;
        begin
            k = KIND_UNKNOWN;
            if (code >= MK_SOF_FIRST && code <= MK_SOF_LAST) begin
                if (code == MK_DHT)
                    k = KIND_DHT;
                else if (code == MK_JPG)
                    k = KIND_JPG;
                else if (code == MK_DAC)
                    k = KIND_DAC;
                else
                    k = KIND_SOF;
            end else if (code >= MK_RST_FIRST && code <= MK_RST_LAST) begin
                k = KIND_RST;
            end else if (code >= MK_SOI && code <= MK_EXP) begin
                k = KIND_SOI + KIND_BITS'(code - MK_SOI);
            end else if (code >= MK_APP_FIRST && code <= MK_APP_LAST) begin
                k = KIND_APP;
            end else if (code >= MK_JPG_FIRST && code <= MK_JPG_LAST) begin
                k = KIND_JPG;
            end else if (code == MK_COM) begin
                k = KIND_COM;
            end
            return k;
        end
    endfunction

    // Drop all per-file state
    function void reset_file_state();
        int i;
        begin
            phase        = PH_IDLE;
            ff_seen      = 1'b0;
            byte_offset  = '0;
            len_hi       = '0;
            pay_left     = '0;
            skip_left    = '0;
            region_open  = 1'b0;
            region_start = '0;
            region_kind  = '0;
            region_ord   = '0;
            for (i = 0; i < NUM_KINDS; i++)
                kind_count[i] = '0;
        end
    endfunction

    function void queue_segment(input logic [KIND_BITS-1:0] kind,
                                input logic [COUNT_BITS-1:0] ord,
                                input logic [OFFSET_BITS-1:0] s_off,
                                input logic [OFFSET_BITS-1:0] e_off,
                                input logic bad);
        t_seg_result seg;
        begin
            seg.segment_kind = kind;
            seg.ordinal      = ord;
            seg.start_offset = s_off;
            seg.end_offset   = e_off;
            seg.bad_length   = bad;
            expected_segments.push_back(seg);
        end
    endfunction

    // Advance the shadow state by one byte and queue any segment it closes
    function void track_byte(input logic [7:0] d, input logic first, input logic last);
        logic [OFFSET_BITS-1:0] o;
        logic [OFFSET_BITS-1:0] p;
        logic [LEN_BITS-1:0]    len;
        logic [LEN_BITS-1:0]    plen;
        logic [KIND_BITS-1:0]   kind;
        logic [COUNT_BITS-1:0]  ord;
        logic [7:0]             skip;
        logic                   bad;
        logic                   got;
        begin
            got = 1'b0;
            if (first)
                reset_file_state();
            o = byte_offset;

            case (phase)
                PH_LEN_HI: begin
                    len_hi = d;
                    phase  = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    len  = {len_hi, d};
                    bad  = (len < LEN_BITS'(2));
                    plen = bad ? '0 : len - LEN_BITS'(2);
                    queue_segment(region_kind, region_ord, o + 1, o + OFFSET_BITS'(plen), bad);
                    got      = 1'b1;
                    pay_left = plen;
                    phase    = (plen != 0) ? PH_PAYLOAD : PH_IDLE;
                end
                PH_PAYLOAD: begin
                    if (pay_left > 0)
                        pay_left = pay_left - 1'b1;
                    if (pay_left == 0)
                        phase = PH_IDLE;
                end
                PH_SCAN_SKIP: begin
                    if (skip_left > 0)
                        skip_left = skip_left - 1'b1;
                    if (skip_left == 0) begin
                        phase       = PH_IDLE;
                        region_open = !last;
                    end
                end
                default: begin
                    phase = PH_IDLE;
                    if (ff_seen && d != BYTE_STUFF && d != BYTE_FF) begin
                        p    = o - 1;
                        kind = marker_kind(d);
                        ord  = kind_count[kind];
                        if (kind_count[kind] != {COUNT_BITS{1'b1}})
                            kind_count[kind] = kind_count[kind] + 1'b1;
                        ff_seen = 1'b0;
                        // A new marker closes the open region at the byte before its FF
                        if (region_open) begin
                            queue_segment(region_kind, region_ord, region_start, o - 2, 1'b0);
                            got         = 1'b1;
                            region_open = 1'b0;
                        end
                        if (kind == KIND_RST || kind == KIND_SOI || kind == KIND_EOI) begin
                            if (last) begin
                                if (!got) begin
                                    queue_segment(kind, ord, p, o, 1'b0);
                                    got = 1'b1;
                                end
                            end else begin
                                region_open  = 1'b1;
                                region_start = p;
                                region_kind  = kind;
                                region_ord   = ord;
                            end
                        end else if (kind == KIND_SOS) begin
                            skip         = (skip_reg < SKIP_MIN) ? SKIP_MIN : skip_reg;
                            region_kind  = kind;
                            region_ord   = ord;
                            region_start = p + OFFSET_BITS'(skip);
                            skip_left    = skip - SKIP_MIN;
                            if (skip_left == 0)
                                region_open = !last;
                            else
                                phase = PH_SCAN_SKIP;
                        end else begin
                            region_kind = kind;
                            region_ord  = ord;
                            phase       = PH_LEN_HI;
                        end
                    end else begin
                        ff_seen = (d == BYTE_FF);
                    end
                end
            endcase

            // Close everything on the final byte
            if (last) begin
                if (region_open && !got)
                    queue_segment(region_kind, region_ord, region_start, o, 1'b0);
                region_open = 1'b0;
                phase       = PH_IDLE;
                ff_seen     = 1'b0;
                pay_left    = '0;
                skip_left   = '0;
            end
            byte_offset = o + 1;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_file_state();
            skip_reg = SKIP_RESET;
            expected_segments.delete();
        end else begin
            // Compare a result request with the oldest prediction
            if (i_m_tvalid && i_m_tready) begin
                seg_got.segment_kind = i_m_tdata[KIND_BITS-1:0];
                seg_got.ordinal      = i_m_tdata[KIND_BITS +: COUNT_BITS];
                seg_got.start_offset = i_m_tdata[KIND_BITS+COUNT_BITS +: OFFSET_BITS];
                seg_got.end_offset   = i_m_tdata[KIND_BITS+COUNT_BITS+OFFSET_BITS +: OFFSET_BITS];
                seg_got.bad_length   = i_m_tuser;
                if (expected_segments.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    if (report_count < MAX_REPORTS)
                        $display("%0t: unexpected segment kind %0d ord %0d start %h end %h bad %0d",
                                 $time, seg_got.segment_kind, seg_got.ordinal,
                                 seg_got.start_offset, seg_got.end_offset, seg_got.bad_length);
                    report_count = report_count + 1;
                end else begin
                    seg_want = expected_segments.pop_front();
                    if (seg_got.segment_kind !== seg_want.segment_kind ||
                        seg_got.ordinal      !== seg_want.ordinal ||
                        seg_got.start_offset !== seg_want.start_offset ||
                        seg_got.end_offset   !== seg_want.end_offset ||
                        seg_got.bad_length   !== seg_want.bad_length) begin
                        o_fail_count = o_fail_count + 1;
                        if (report_count < MAX_REPORTS) begin
                            $display("%0t: expected kind %0d ord %0d start %h end %h bad %0d",
                                     $time, seg_want.segment_kind, seg_want.ordinal,
                                     seg_want.start_offset, seg_want.end_offset,
                                     seg_want.bad_length);
                            $display("%0t:      got kind %0d ord %0d start %h end %h bad %0d",
                                     $time, seg_got.segment_kind, seg_got.ordinal,
                                     seg_got.start_offset, seg_got.end_offset,
                                     seg_got.bad_length);
                        end
                        report_count = report_count + 1;
                    end
                end
            end
            // Predict from an accepted byte request
            if (i_s_tvalid && i_s_tready)
                track_byte(i_s_tdata, i_s_tuser, i_s_tlast);
            // Follow register writes
            if (i_psel && i_penable && i_pwrite && i_pready && (i_paddr >> 2) == REG_SCAN_SKIP)
                skip_reg = i_pwdata[7:0];
        end
        o_pending = expected_segments.size();
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Stimulus top for the JPEG marker segment locator: builds directed and random files,
// drives the byte stream and register port, and reports the verdict.
// Depends on jmsl_pkg, jmsl_tb_pkg, jmsl_segment_checker and the locator RTL.
module testbench;
    import jmsl_pkg::*;
    import jmsl_tb_pkg::*;

    localparam int LIMIT         = 400000;
    localparam int MAX_GAP       = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int NUM_PHASES    = 6;
    localparam int PHASE_BYTES   = 30;
    localparam int STORM_PHASE   = 4;
    localparam int STORM_MARKERS = 262;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic        m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    bit          idle_on = 1'b1;
    logic [7:0]  cur_skip = SKIP_RESET;
    logic [7:0]  file_buf [$];

    always #5 clk = ~clk;

    jpeg_marker_segment_locator u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_prdata        (prdata),
        .o_pready        (pready)
    );

    jmsl_segment_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Abort a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("[jpeg_marker_segment_locator] ERROR");
            $finish;
        end
    end

    // Stall the result side for a random number of cycles per request
    initial begin : result_sink
        int stall;
        m_tready = 1'b0;
        forever begin
            stall = idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            @(negedge clk);
        end
    end

    // Byte biased toward FF and 00 so markers, fill and stuffing show up often
    function automatic logic [7:0] noisy_byte();
        case ($urandom_range(0, 7))
            0, 1:    return BYTE_FF;
            2:       return BYTE_STUFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Marker code of a segment that carries a length
    function automatic logic [7:0] length_marker_code();
        case ($urandom_range(0, 7))
            0:       return MK_SOF_FIRST + 8'($urandom_range(0, 15));
            1:       return MK_DHT;
            2:       return MK_DQT + 8'($urandom_range(0, 4));
            3:       return MK_APP_FIRST + 8'($urandom_range(0, 15));
            4:       return MK_JPG_FIRST + 8'($urandom_range(0, 13));
            5:       return MK_COM;
            default: return 8'($urandom_range(MK_UNKNOWN_FIRST, MK_UNKNOWN_LAST));
        endcase
    endfunction

    // Send one byte request after a random gap, hold it until accepted
    task automatic send_byte(input logic [7:0] d, input logic first, input logic last);
        int gap;
        begin
            gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= d;
            s_tuser  <= first;
            s_tlast  <= last;
            @(posedge clk);
            while (!s_tready) @(posedge clk);
            @(negedge clk);
        end
    endtask

    task automatic send_file(input logic head, input logic tail);
        int i;
        begin
            for (i = 0; i < file_buf.size(); i++)
                send_byte(file_buf[i], head && i == 0, tail && i == file_buf.size() - 1);
        end
    endtask

    // Hold off until every prediction has been matched and the pipeline is empty
    task automatic drain_block();
        begin
            s_tvalid <= 1'b0;
            while (pending != 0) @(negedge clk);
            repeat (SETTLE_CYCLES) @(negedge clk);
        end
    endtask

    task automatic write_scan_skip(input logic [7:0] value);
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {REG_SCAN_SKIP, 2'b00};
            pwdata  <= {24'd0, value};
            @(negedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready) @(posedge clk);
            @(negedge clk);
            psel     <= 1'b0;
            penable  <= 1'b0;
            pwrite   <= 1'b0;
            cur_skip  = value;
        end
    endtask

    task automatic add_length_segment(input logic [7:0] code);
        int seg_len;
        int i;
        begin
            case ($urandom_range(0, 15))
                0:       seg_len = $urandom_range(0, 1);
                1:       seg_len = $urandom_range(100, 300);
                default: seg_len = $urandom_range(2, 12);
            endcase
            file_buf.push_back(BYTE_FF);
            file_buf.push_back(code);
            file_buf.push_back(8'(seg_len >> 8));
            file_buf.push_back(8'(seg_len));
            for (i = 2; i < seg_len; i++)
                file_buf.push_back(noisy_byte());
        end
    endtask

    // Entropy-coded data with stuffed bytes, fill and restart markers
    task automatic add_scan_data(input int n);
        int i;
        begin
            for (i = 0; i < n; i++) begin
                case ($urandom_range(0, 9))
                    0: begin
                        file_buf.push_back(BYTE_FF);
                        file_buf.push_back(BYTE_STUFF);
                    end
                    1: begin
                        file_buf.push_back(BYTE_FF);
                        file_buf.push_back(BYTE_FF);
                    end
                    2: begin
                        file_buf.push_back(BYTE_FF);
                        file_buf.push_back(MK_RST_FIRST + 8'($urandom_range(0, 7)));
                    end
                    default: file_buf.push_back(8'($urandom_range(0, BYTE_FF - 1)));
                endcase
            end
        end
    endtask

    // Well-formed file, sometimes with trailing junk or cut short
    task automatic build_jpeg_file();
        int n;
        int hdr;
        int cut;
        int i;
        begin
            file_buf.delete();
            file_buf.push_back(BYTE_FF);
            file_buf.push_back(MK_SOI);
            n = $urandom_range(0, 4);
            for (i = 0; i < n; i++)
                add_length_segment(length_marker_code());
            if ($urandom_range(0, 7) != 0) begin
                file_buf.push_back(BYTE_FF);
                file_buf.push_back(MK_SOS);
                hdr = int'(((cur_skip < SKIP_MIN) ? SKIP_MIN : cur_skip) - SKIP_MIN);
                for (i = 0; i < hdr; i++)
                    file_buf.push_back(noisy_byte());
                add_scan_data(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24));
            end
            file_buf.push_back(BYTE_FF);
            file_buf.push_back(MK_EOI);
            if ($urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++)
                    file_buf.push_back(noisy_byte());
            end
            if ($urandom_range(0, 4) == 0) begin
                cut = $urandom_range(1, file_buf.size());
                while (file_buf.size() > cut) file_buf.pop_back();
            end
        end
    endtask

    task automatic build_noise_file();
        int n;
        int i;
        begin
            file_buf.delete();
            n = $urandom_range(4, 40);
            for (i = 0; i < n; i++)
                file_buf.push_back(noisy_byte());
        end
    endtask

    // Enough restart markers to saturate their counter
    task automatic build_rst_storm();
        int i;
        begin
            file_buf.delete();
            file_buf.push_back(BYTE_FF);
            file_buf.push_back(MK_SOI);
            for (i = 0; i < STORM_MARKERS; i++) begin
                file_buf.push_back(BYTE_FF);
                file_buf.push_back(MK_RST_FIRST + 8'($urandom_range(0, 7)));
            end
            file_buf.push_back(BYTE_FF);
            file_buf.push_back(MK_EOI);
        end
    endtask

    initial begin : stimulus
        int         ph;
        int         phase_bytes;
        logic       head;
        logic       tail;
        logic [7:0] skip_plan [NUM_PHASES];

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        s_tlast  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // SOI region, length payload holding a marker, bad length, EOI on the final byte
        file_buf = {BYTE_FF, MK_SOI, BYTE_FF, MK_APP_LAST, 8'h00, 8'h04, BYTE_FF, MK_EOI,
                    BYTE_FF, MK_DHT, 8'h00, 8'h00, BYTE_FF, MK_EOI};
        send_file(1'b1, 1'b1);
        // Fill and stuffing inside a region, restart marker on the final byte
        file_buf = {BYTE_FF, MK_SOI, BYTE_FF, BYTE_FF, BYTE_STUFF, BYTE_FF, MK_RST_FIRST};
        send_file(1'b1, 1'b1);

        skip_plan[0] = SKIP_MIN;
        skip_plan[1] = 8'd0;
        skip_plan[2] = 8'd255;
        skip_plan[3] = 8'd1;
        skip_plan[4] = 8'($urandom_range(3, 40));
        skip_plan[5] = SKIP_RESET;

        // Random files under each scan header setting
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            drain_block();
            write_scan_skip(skip_plan[ph]);
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                idle_on = ($urandom_range(0, 3) != 0);
                head    = ($urandom_range(0, 7) != 0);
                tail    = ($urandom_range(0, 7) != 0);
                if (ph == STORM_PHASE && phase_bytes == 0) begin
                    build_rst_storm();
                    head = 1'b1;
                    tail = 1'b1;
                end else if ($urandom_range(0, 4) == 0) begin
                    build_noise_file();
                end else begin
                    build_jpeg_file();
                end
                send_file(head, tail);
                phase_bytes = phase_bytes + file_buf.size();
            end
        end

        drain_block();
        if (fail_count == 0)
            $display("[jpeg_marker_segment_locator] OK");
        else
            $display("[jpeg_marker_segment_locator] ERROR");
        $finish;
    end

endmodule
